// ----- hdl/lmm_pkg.sv -----
// ----------------------------------------------------------------------------
// lmm_pkg: shared definitions for the landmark match and merge block
// Table geometry, result codes, sequencer states, the table control word and a saturating increment.
// ----------------------------------------------------------------------------
`default_nettype none

package lmm_pkg;

    localparam int MAP_DEPTH = 1024;
    localparam int IDX_W     = 10;
    localparam int FILL_W    = 11;
    localparam int CNT_BITS  = 16;
    localparam int RADIUS_W  = 51;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 51'd1048576;

    typedef enum logic [2:0] {
        ST_MATCHED  = 3'd0,
        ST_NO_MATCH = 3'd1,
        ST_MERGED   = 3'd2,
        ST_SPAWNED  = 3'd3,
        ST_FULL     = 3'd4,
        ST_INVALID  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_X,
        S_SCAN_Y,
        S_SCAN_Z,
        S_SCAN_CMP,
        S_MATCH_END,
        S_MARK_RD,
        S_MARK_WR,
        S_MRG_RD,
        S_MRG_MUL,
        S_MRG_DIV,
        S_MRG_WAIT,
        S_MRG_WR,
        S_SPAWN,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             entry_we;
        logic             used_we;
        logic             used_wdata;
        logic [IDX_W-1:0] addr;
    } tbl_ctl_t;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c);
        sat_inc = (c == {CNT_BITS{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/landmark_match_and_merge.sv -----
// ----------------------------------------------------------------------------
// landmark_match_and_merge: greedy point association against a map table
// A table of up to 1024 map points; match items look for the closest unused
// entry inside the match radius, merge items blend into or append to the table.
// ----------------------------------------------------------------------------
// Usage. One word enters on s_valid/s_ready and exactly one result word leaves
// on m_valid/m_ready. The block takes one input word at a time; s_ready stays
// low from acceptance until the result has been loaded into the output
// register. The output register holds the result while the receiver stalls,
// and the next input word is already accepted then.
// A match word walks every filled entry, one entry read per table access. An
// entry marked used is passed over after its read unless the word starts a
// frame, and an invalid point passes over every entry; the others have dx, dy
// and dz squared in turn by the single shared multiplier. A frame start clears
// the used marks in the same walk. A merge with a valid id blends each
// coordinate in turn through the bit-serial divider. A spawn appends the point
// at the next free entry; a full table or invalid merge point goes to the result.
// The cfg channel writes the squared match radius and is always ready.
// Reset empties the table (entry_count 0) and loads the default radius; it
// needs no clearing pass since only filled entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module landmark_match_and_merge #(
    parameter int COORD_BITS = 24
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire        [lmm_pkg::RADIUS_W-1:0]  cfg_data,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_mode,
    input  wire                                 s_frame_start,
    input  wire                                 s_point_valid,
    input  wire signed [COORD_BITS-1:0]         s_pos_x,
    input  wire signed [COORD_BITS-1:0]         s_pos_y,
    input  wire signed [COORD_BITS-1:0]         s_pos_z,
    input  wire                                 s_has_map_id,
    input  wire        [lmm_pkg::IDX_W-1:0]     s_map_id,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic       [2:0]                    m_status,
    output logic       [lmm_pkg::IDX_W-1:0]     m_entry_id,
    output logic       [lmm_pkg::FILL_W-1:0]    m_entry_count
);

    localparam int MW     = (COORD_BITS + 1 > 18) ? COORD_BITS + 1 : 18;
    localparam int PW     = 2 * MW;
    localparam int SUM_W  = PW + 2;
    localparam int CMP_W  = (SUM_W > lmm_pkg::RADIUS_W) ? SUM_W : lmm_pkg::RADIUS_W;
    localparam int NUM_W  = COORD_BITS + 16;
    localparam int DEN_W  = lmm_pkg::CNT_BITS + 1;
    localparam int CB     = lmm_pkg::CNT_BITS;
    localparam int IW     = lmm_pkg::IDX_W;

    lmm_pkg::state_t  state_reg, state_next;
    lmm_pkg::tbl_ctl_t tctl;

    logic [lmm_pkg::RADIUS_W-1:0] radius_reg;
    logic [lmm_pkg::FILL_W-1:0]   filled_reg, filled_next;

    logic                         fstart_reg, pvalid_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;
    logic [IW-1:0]                id_reg;

    logic [IW-1:0]                idx_reg, idx_next;
    logic [IW-1:0]                best_i_reg, best_i_next;
    logic [lmm_pkg::RADIUS_W-1:0] best_reg, best_next;
    logic                         found_reg, found_next;
    logic signed [PW-1:0]         prod_reg, prod_next;
    logic [SUM_W-1:0]             acc_reg, acc_next;
    logic [1:0]                   k_reg, k_next;
    logic                         neg_reg, neg_next;
    logic [COORD_BITS-1:0]        nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    lmm_pkg::status_t             res_status_reg, res_status_next;
    logic [IW-1:0]                res_id_reg, res_id_next;

    logic                         m_valid_reg;
    lmm_pkg::status_t             m_status_reg;
    logic [IW-1:0]                m_id_reg;
    logic [lmm_pkg::FILL_W-1:0]   m_count_reg;

    logic [COORD_BITS-1:0] rd_x, rd_y, rd_z;
    logic [CB-1:0]         rd_sources, rd_hits, rd_attempts;
    logic                  rd_used;
    logic [COORD_BITS-1:0] wr_x, wr_y, wr_z;
    logic [CB-1:0]         wr_sources, wr_hits, wr_attempts;

    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [MW-1:0]  dx, dy, dz;
    logic [CB-1:0]         weight;
    logic [DEN_W-1:0]      den;
    logic [COORD_BITS-1:0] old_k, new_k;
    logic signed [PW-1:0]  num;
    logic [PW-1:0]         mag;
    logic [NUM_W-1:0]      div_num;
    logic                  div_start, div_done;
    logic [NUM_W-1:0]      div_quo;
    logic [COORD_BITS-1:0] blended;
    logic [SUM_W-1:0]      dist_sum;
    logic [CMP_W-1:0]      dist_cmp;
    logic                  s_fire, out_free, last_entry;

    lmm_table #(.COORD_BITS(COORD_BITS)) u_table (
        .aclk        (aclk),
        .ctl         (tctl),
        .wr_x        (wr_x),
        .wr_y        (wr_y),
        .wr_z        (wr_z),
        .wr_sources  (wr_sources),
        .wr_hits     (wr_hits),
        .wr_attempts (wr_attempts),
        .rd_x        (rd_x),
        .rd_y        (rd_y),
        .rd_z        (rd_z),
        .rd_sources  (rd_sources),
        .rd_hits     (rd_hits),
        .rd_attempts (rd_attempts),
        .rd_used     (rd_used)
    );

    lmm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == lmm_pkg::S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // Coordinate differences; the entry word stays on the read port while
    // the address is held.
    assign dx = $signed({{(MW-COORD_BITS){rd_x[COORD_BITS-1]}}, rd_x})
              - $signed({{(MW-COORD_BITS){px_reg[COORD_BITS-1]}}, px_reg});
    assign dy = $signed({{(MW-COORD_BITS){rd_y[COORD_BITS-1]}}, rd_y})
              - $signed({{(MW-COORD_BITS){py_reg[COORD_BITS-1]}}, py_reg});
    assign dz = $signed({{(MW-COORD_BITS){rd_z[COORD_BITS-1]}}, rd_z})
              - $signed({{(MW-COORD_BITS){pz_reg[COORD_BITS-1]}}, pz_reg});

    assign weight = (rd_sources == '0) ? CB'(1) : rd_sources;
    assign den    = {1'b0, weight} + DEN_W'(1);

    always_comb begin
        case (k_reg)
            2'd0:    begin old_k = rd_x; new_k = px_reg; end
            2'd1:    begin old_k = rd_y; new_k = py_reg; end
            default: begin old_k = rd_z; new_k = pz_reg; end
        endcase
    end

    // Rounded blend: |num| plus half the divisor, sign restored after division.
    assign num     = prod_reg + $signed({{(PW-COORD_BITS){new_k[COORD_BITS-1]}}, new_k});
    assign mag     = num[PW-1] ? PW'(-num) : PW'(num);
    assign div_num = mag[NUM_W-1:0] + NUM_W'(den[DEN_W-1:1]);
    assign blended = neg_reg ? COORD_BITS'(-div_quo[COORD_BITS-1:0])
                             : div_quo[COORD_BITS-1:0];

    assign dist_sum   = acc_reg + SUM_W'(prod_reg);
    assign dist_cmp   = CMP_W'(dist_sum);
    assign last_entry = ({1'b0, idx_reg} + lmm_pkg::FILL_W'(1)) == filled_reg;

    always_comb begin
        unique case (state_reg)
            lmm_pkg::S_SCAN_Y:  begin mul_a = dy; mul_b = dy; end
            lmm_pkg::S_SCAN_Z:  begin mul_a = dz; mul_b = dz; end
            lmm_pkg::S_MRG_MUL: begin
                mul_a = $signed(MW'(weight));
                mul_b = $signed({{(MW-COORD_BITS){old_k[COORD_BITS-1]}}, old_k});
            end
            default:            begin mul_a = dx; mul_b = dx; end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        filled_next     = filled_reg;
        idx_next        = idx_reg;
        best_i_next     = best_i_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        k_next          = k_reg;
        neg_next        = neg_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        nz_next         = nz_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        div_start       = 1'b0;
        tctl.entry_we   = 1'b0;
        tctl.used_we    = 1'b0;
        tctl.used_wdata = 1'b0;
        tctl.addr       = idx_reg;
        wr_x            = px_reg;
        wr_y            = py_reg;
        wr_z            = pz_reg;
        wr_sources      = CB'(1);
        wr_hits         = '0;
        wr_attempts     = '0;

        unique case (state_reg)
            lmm_pkg::S_IDLE: begin
                if (s_fire) begin
                    idx_next    = '0;
                    found_next  = 1'b0;
                    best_next   = radius_reg;
                    res_id_next = '0;
                    if (!s_mode) begin
                        state_next = (filled_reg == '0) ? lmm_pkg::S_MATCH_END
                                                        : lmm_pkg::S_SCAN_RD;
                    end else if (!s_point_valid) begin
                        res_status_next = lmm_pkg::ST_INVALID;
                        state_next      = lmm_pkg::S_OUT;
                    end else if (s_has_map_id && ({1'b0, s_map_id} < filled_reg)) begin
                        state_next = lmm_pkg::S_MRG_RD;
                    end else if (filled_reg == lmm_pkg::FILL_W'(lmm_pkg::MAP_DEPTH)) begin
                        res_status_next = lmm_pkg::ST_FULL;
                        state_next      = lmm_pkg::S_OUT;
                    end else begin
                        state_next = lmm_pkg::S_SPAWN;
                    end
                end
            end
            lmm_pkg::S_SCAN_RD: begin
                state_next = lmm_pkg::S_SCAN_X;
            end
            lmm_pkg::S_SCAN_X: begin
                // A frame start clears each mark as the walk passes it.
                if (fstart_reg) begin
                    tctl.used_we = 1'b1;
                end
                if (!pvalid_reg || (rd_used && !fstart_reg)) begin
                    idx_next   = last_entry ? idx_reg : idx_reg + 1'b1;
                    state_next = last_entry ? lmm_pkg::S_MATCH_END : lmm_pkg::S_SCAN_RD;
                end else begin
                    prod_next  = mul_a * mul_b;
                    state_next = lmm_pkg::S_SCAN_Y;
                end
            end
            lmm_pkg::S_SCAN_Y: begin
                acc_next   = SUM_W'(prod_reg);
                prod_next  = mul_a * mul_b;
                state_next = lmm_pkg::S_SCAN_Z;
            end
            lmm_pkg::S_SCAN_Z: begin
                acc_next   = dist_sum;
                prod_next  = mul_a * mul_b;
                state_next = lmm_pkg::S_SCAN_CMP;
            end
            lmm_pkg::S_SCAN_CMP: begin
                if (dist_cmp < CMP_W'(best_reg)) begin
                    best_next   = dist_cmp[lmm_pkg::RADIUS_W-1:0];
                    best_i_next = idx_reg;
                    found_next  = 1'b1;
                end
                idx_next   = last_entry ? idx_reg : idx_reg + 1'b1;
                state_next = last_entry ? lmm_pkg::S_MATCH_END : lmm_pkg::S_SCAN_RD;
            end
            lmm_pkg::S_MATCH_END: begin
                if (!pvalid_reg) begin
                    res_status_next = lmm_pkg::ST_INVALID;
                    state_next      = lmm_pkg::S_OUT;
                end else if (found_reg) begin
                    state_next = lmm_pkg::S_MARK_RD;
                end else begin
                    res_status_next = lmm_pkg::ST_NO_MATCH;
                    state_next      = lmm_pkg::S_OUT;
                end
            end
            lmm_pkg::S_MARK_RD: begin
                tctl.addr  = best_i_reg;
                state_next = lmm_pkg::S_MARK_WR;
            end
            lmm_pkg::S_MARK_WR: begin
                tctl.addr       = best_i_reg;
                tctl.entry_we   = 1'b1;
                tctl.used_we    = 1'b1;
                tctl.used_wdata = 1'b1;
                wr_x            = rd_x;
                wr_y            = rd_y;
                wr_z            = rd_z;
                wr_sources      = rd_sources;
                wr_hits         = rd_hits;
                wr_attempts     = lmm_pkg::sat_inc(rd_attempts);
                res_status_next = lmm_pkg::ST_MATCHED;
                res_id_next     = best_i_reg;
                state_next      = lmm_pkg::S_OUT;
            end
            lmm_pkg::S_MRG_RD: begin
                tctl.addr  = id_reg;
                k_next     = '0;
                state_next = lmm_pkg::S_MRG_MUL;
            end
            lmm_pkg::S_MRG_MUL: begin
                tctl.addr  = id_reg;
                prod_next  = mul_a * mul_b;
                state_next = lmm_pkg::S_MRG_DIV;
            end
            lmm_pkg::S_MRG_DIV: begin
                tctl.addr  = id_reg;
                div_start  = 1'b1;
                neg_next   = num[PW-1];
                state_next = lmm_pkg::S_MRG_WAIT;
            end
            lmm_pkg::S_MRG_WAIT: begin
                tctl.addr = id_reg;
                if (div_done) begin
                    case (k_reg)
                        2'd0:    nx_next = blended;
                        2'd1:    ny_next = blended;
                        default: nz_next = blended;
                    endcase
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg == 2'd2) ? lmm_pkg::S_MRG_WR : lmm_pkg::S_MRG_MUL;
                end
            end
            lmm_pkg::S_MRG_WR: begin
                tctl.addr       = id_reg;
                tctl.entry_we   = 1'b1;
                wr_x            = nx_reg;
                wr_y            = ny_reg;
                wr_z            = nz_reg;
                wr_sources      = lmm_pkg::sat_inc(rd_sources);
                wr_hits         = lmm_pkg::sat_inc(rd_hits);
                wr_attempts     = rd_attempts;
                res_status_next = lmm_pkg::ST_MERGED;
                res_id_next     = id_reg;
                state_next      = lmm_pkg::S_OUT;
            end
            lmm_pkg::S_SPAWN: begin
                tctl.addr       = filled_reg[IW-1:0];
                tctl.entry_we   = 1'b1;
                tctl.used_we    = 1'b1;
                filled_next     = filled_reg + 1'b1;
                res_status_next = lmm_pkg::ST_SPAWNED;
                res_id_next     = filled_reg[IW-1:0];
                state_next      = lmm_pkg::S_OUT;
            end
            lmm_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = lmm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lmm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lmm_pkg::S_IDLE;
            filled_reg  <= '0;
            radius_reg  <= lmm_pkg::RADIUS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            if (cfg_valid && cfg_ready) begin
                radius_reg <= cfg_data;
            end
            if ((state_reg == lmm_pkg::S_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            fstart_reg <= s_frame_start;
            pvalid_reg <= s_point_valid;
            px_reg     <= s_pos_x;
            py_reg     <= s_pos_y;
            pz_reg     <= s_pos_z;
            id_reg     <= s_map_id;
        end
        idx_reg        <= idx_next;
        best_i_reg     <= best_i_next;
        best_reg       <= best_next;
        found_reg      <= found_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        k_reg          <= k_next;
        neg_reg        <= neg_next;
        nx_reg         <= nx_next;
        ny_reg         <= ny_next;
        nz_reg         <= nz_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        if ((state_reg == lmm_pkg::S_OUT) && out_free) begin
            m_status_reg <= res_status_reg;
            m_id_reg     <= res_id_reg;
            m_count_reg  <= filled_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_id    = m_id_reg;
    assign m_entry_count = m_count_reg;

endmodule

`default_nettype wire

// ----- hdl/lmm_table.sv -----
// ----------------------------------------------------------------------------
// lmm_table: map entry storage
// One entry memory and one used-mark memory sharing an address, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module lmm_table #(
    parameter int COORD_BITS = 24
) (
    input  wire                                 aclk,
    input  wire lmm_pkg::tbl_ctl_t              ctl,
    input  wire        [COORD_BITS-1:0]         wr_x,
    input  wire        [COORD_BITS-1:0]         wr_y,
    input  wire        [COORD_BITS-1:0]         wr_z,
    input  wire        [lmm_pkg::CNT_BITS-1:0]  wr_sources,
    input  wire        [lmm_pkg::CNT_BITS-1:0]  wr_hits,
    input  wire        [lmm_pkg::CNT_BITS-1:0]  wr_attempts,
    output logic       [COORD_BITS-1:0]         rd_x,
    output logic       [COORD_BITS-1:0]         rd_y,
    output logic       [COORD_BITS-1:0]         rd_z,
    output logic       [lmm_pkg::CNT_BITS-1:0]  rd_sources,
    output logic       [lmm_pkg::CNT_BITS-1:0]  rd_hits,
    output logic       [lmm_pkg::CNT_BITS-1:0]  rd_attempts,
    output logic                                rd_used
);

    localparam int WORD_W = 3 * COORD_BITS + 3 * lmm_pkg::CNT_BITS;

    logic [WORD_W-1:0] entry_mem [lmm_pkg::MAP_DEPTH];
    logic              used_mem  [lmm_pkg::MAP_DEPTH];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge aclk) begin
        if (ctl.entry_we) begin
            entry_mem[ctl.addr] <= {wr_x, wr_y, wr_z, wr_sources, wr_hits, wr_attempts};
        end
        rd_word_reg <= entry_mem[ctl.addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.used_we) begin
            used_mem[ctl.addr] <= ctl.used_wdata;
        end
        rd_used <= used_mem[ctl.addr];
    end

    assign {rd_x, rd_y, rd_z, rd_sources, rd_hits, rd_attempts} = rd_word_reg;

endmodule

`default_nettype wire

// ----- hdl/lmm_div.sv -----
// ----------------------------------------------------------------------------
// lmm_div: unsigned restoring divider
// Produces one quotient bit per cycle; done pulses as the last bit is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lmm_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 17
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  wire  [NUM_W-1:0]  num,
    input  wire  [DEN_W-1:0]  den,
    output logic              done,
    output logic [NUM_W-1:0]  quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // Numerator bits shift out of the top as quotient bits shift in.
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- hdl/lmm_checker.sv -----
// ----------------------------------------------------------------------------
// lmm_checker: port-level checks for the landmark match and merge block
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lmm_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           m_valid,
    input wire                           m_ready,
    input wire [2:0]                     m_status,
    input wire [lmm_pkg::IDX_W-1:0]      m_entry_id,
    input wire [lmm_pkg::FILL_W-1:0]     m_entry_count
);

    // A stalled result word must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entry_id))
        else $error("result word changed while stalled");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= lmm_pkg::FILL_W'(lmm_pkg::MAP_DEPTH))
        else $error("entry count beyond table depth");

    // Results without an entry carry id zero.
    a_noid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == lmm_pkg::ST_NO_MATCH || m_status == lmm_pkg::ST_FULL
                    || m_status == lmm_pkg::ST_INVALID) |-> m_entry_id == '0)
        else $error("entry id set on a result without an entry");

    // A new entry is always the last one of the table.
    a_spawn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lmm_pkg::ST_SPAWNED
            |-> {1'b0, m_entry_id} + lmm_pkg::FILL_W'(1) == m_entry_count)
        else $error("spawned id is not the last entry");

    // A matched or merged id names a filled entry.
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == lmm_pkg::ST_MATCHED || m_status == lmm_pkg::ST_MERGED)
            |-> {1'b0, m_entry_id} < m_entry_count)
        else $error("result id beyond filled entries");

endmodule

bind landmark_match_and_merge lmm_checker u_lmm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_entry_id    (m_entry_id),
    .m_entry_count (m_entry_count)
);

`default_nettype wire

// ----- bench/landmark_match_and_merge_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// landmark_match_and_merge_test: self-checking bench for the map matcher
// Words go in through a queue-fed driver with random gaps. Each accepted word
// runs through a local copy of the map table to get its expected result.
// A stalling monitor checks every result word against the oldest expectation.
// The radius register is rewritten between phases, and the last phase runs
// without idling.
// ----------------------------------------------------------------------------
`default_nettype none

module landmark_match_and_merge_test;

    localparam int CW = 24;
    localparam logic [lmm_pkg::RADIUS_W-1:0] RADIUS_ALL_ONES = {lmm_pkg::RADIUS_W{1'b1}};

    typedef struct {
        bit                            mode;
        bit                            fs;
        bit                            pv;
        logic signed [CW-1:0]          x;
        logic signed [CW-1:0]          y;
        logic signed [CW-1:0]          z;
        bit                            has_id;
        logic [lmm_pkg::IDX_W-1:0]     id;
    } point_word_t;

    typedef struct {
        lmm_pkg::status_t              status;
        logic [lmm_pkg::IDX_W-1:0]     id;
        logic [lmm_pkg::FILL_W-1:0]    count;
    } assoc_result_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_valid = 1'b0;
    wire                               cfg_ready;
    logic [lmm_pkg::RADIUS_W-1:0]      cfg_data = '0;
    logic                              s_valid = 1'b0;
    wire                               s_ready;
    logic                              s_mode = 1'b0;
    logic                              s_frame_start = 1'b0;
    logic                              s_point_valid = 1'b0;
    logic signed [CW-1:0]              s_pos_x = '0;
    logic signed [CW-1:0]              s_pos_y = '0;
    logic signed [CW-1:0]              s_pos_z = '0;
    logic                              s_has_map_id = 1'b0;
    logic [lmm_pkg::IDX_W-1:0]         s_map_id = '0;
    wire                               m_valid;
    logic                              m_ready = 1'b0;
    wire  [2:0]                        m_status;
    wire  [lmm_pkg::IDX_W-1:0]         m_entry_id;
    wire  [lmm_pkg::FILL_W-1:0]        m_entry_count;

    landmark_match_and_merge #(.COORD_BITS(CW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_frame_start(s_frame_start), .s_point_valid(s_point_valid),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_has_map_id(s_has_map_id), .s_map_id(s_map_id),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_entry_id(m_entry_id), .m_entry_count(m_entry_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Local copy of the map table.
    logic [lmm_pkg::RADIUS_W-1:0] radius_sq = lmm_pkg::RADIUS_RESET;
    longint              tbl_x [lmm_pkg::MAP_DEPTH];
    longint              tbl_y [lmm_pkg::MAP_DEPTH];
    longint              tbl_z [lmm_pkg::MAP_DEPTH];
    int unsigned         tbl_sources [lmm_pkg::MAP_DEPTH];
    bit                  tbl_used [lmm_pkg::MAP_DEPTH];
    int                  tbl_filled = 0;

    point_word_t         pending_words[$];
    assoc_result_t       expected_results[$];
    point_word_t         held_word;
    int                  fails = 0;
    bit                  calm = 1'b0;
    int                  src_gap = 0;
    int                  sink_stall = 0;

    // Generator-side view of the table, used to aim points at entries.
    int                  gen_filled = 0;
    int                  gen_x [lmm_pkg::MAP_DEPTH];
    int                  gen_y [lmm_pkg::MAP_DEPTH];
    int                  gen_z [lmm_pkg::MAP_DEPTH];

    function automatic longint blend_coord(longint old, longint nw, longint w);
        longint num;
        longint den;
        num = w * old + nw;
        den = w + 1;
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint abs_sq(longint a, longint b);
        longint d;
        d = (a >= b) ? a - b : b - a;
        return d * d;
    endfunction

    function automatic assoc_result_t associate(point_word_t w);
        assoc_result_t r;
        longint unsigned best;
        longint unsigned d;
        longint          wt;
        bit              found;
        r.id = '0;
        if (!w.mode) begin
            if (w.fs) foreach (tbl_used[i]) tbl_used[i] = 1'b0;
            if (!w.pv) begin
                r.status = lmm_pkg::ST_INVALID;
            end else begin
                found = 1'b0;
                best = {13'b0, radius_sq};
                for (int i = 0; i < tbl_filled; i++) begin
                    if (tbl_used[i]) continue;
                    d = abs_sq(tbl_x[i], w.x) + abs_sq(tbl_y[i], w.y) + abs_sq(tbl_z[i], w.z);
                    if (d < best) begin
                        best = d;
                        r.id = lmm_pkg::IDX_W'(i);
                        found = 1'b1;
                    end
                end
                if (found) begin
                    tbl_used[r.id] = 1'b1;
                    r.status = lmm_pkg::ST_MATCHED;
                end else begin
                    r.status = lmm_pkg::ST_NO_MATCH;
                end
            end
        end else if (!w.pv) begin
            r.status = lmm_pkg::ST_INVALID;
        end else if (w.has_id && w.id < tbl_filled) begin
            wt = longint'((tbl_sources[w.id] < 1) ? 1 : tbl_sources[w.id]);
            tbl_x[w.id] = blend_coord(tbl_x[w.id], w.x, wt);
            tbl_y[w.id] = blend_coord(tbl_y[w.id], w.y, wt);
            tbl_z[w.id] = blend_coord(tbl_z[w.id], w.z, wt);
            if (tbl_sources[w.id] < 65535) tbl_sources[w.id]++;
            r.status = lmm_pkg::ST_MERGED;
            r.id = w.id;
        end else if (tbl_filled >= lmm_pkg::MAP_DEPTH) begin
            r.status = lmm_pkg::ST_FULL;
        end else begin
            tbl_x[tbl_filled] = w.x;
            tbl_y[tbl_filled] = w.y;
            tbl_z[tbl_filled] = w.z;
            tbl_sources[tbl_filled] = 1;
            tbl_used[tbl_filled] = 1'b0;
            r.status = lmm_pkg::ST_SPAWNED;
            r.id = lmm_pkg::IDX_W'(tbl_filled);
            tbl_filled++;
        end
        r.count = lmm_pkg::FILL_W'(tbl_filled);
        return r;
    endfunction

    // Driver: presents queued words, with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(), associate(held_word));
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0 && !calm && $urandom_range(0, 4) == 0) begin
                src_gap = $urandom_range(0, 6);
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                held_word <= pending_words[0];
                s_mode <= pending_words[0].mode;
                s_frame_start <= pending_words[0].fs;
                s_point_valid <= pending_words[0].pv;
                s_pos_x <= pending_words[0].x;
                s_pos_y <= pending_words[0].y;
                s_pos_z <= pending_words[0].z;
                s_has_map_id <= pending_words[0].has_id;
                s_map_id <= pending_words[0].id;
                void'(pending_words.pop_front());
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: stalls the result channel in bursts and checks each word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: status %0d id %0d count %0d",
                           m_status, m_entry_id, m_entry_count);
                    fails++;
                end else begin
                    if (m_status !== expected_results[0].status) begin
                        $error("status: expected %0d, got %0d",
                               expected_results[0].status, m_status);
                        fails++;
                    end
                    if (m_entry_id !== expected_results[0].id) begin
                        $error("entry_id: expected %0d, got %0d",
                               expected_results[0].id, m_entry_id);
                        fails++;
                    end
                    if (m_entry_count !== expected_results[0].count) begin
                        $error("entry_count: expected %0d, got %0d",
                               expected_results[0].count, m_entry_count);
                        fails++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                sink_stall = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic int clamp_coord(int v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    task automatic add_word(bit mode, bit fs, bit pv, int x, int y, int z,
                            bit has_id, int id);
        point_word_t w;
        w.mode = mode;
        w.fs = fs;
        w.pv = pv;
        w.x = CW'(x);
        w.y = CW'(y);
        w.z = CW'(z);
        w.has_id = has_id;
        w.id = lmm_pkg::IDX_W'(id);
        pending_words.insert(pending_words.size(), w);
        if (mode && pv && !(has_id && w.id < gen_filled) && gen_filled < lmm_pkg::MAP_DEPTH) begin
            gen_x[gen_filled] = w.x;
            gen_y[gen_filled] = w.y;
            gen_z[gen_filled] = w.z;
            gen_filled++;
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_valid || m_valid ||
               expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_radius(logic [lmm_pkg::RADIUS_W-1:0] value);
        wait_drained();
        @(posedge aclk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        radius_sq = value;
    endtask

    // Mostly well-formed traffic aimed at known entries, plus some noise.
    task automatic add_random_word();
        int pick;
        int k;
        int ofs;
        pick = $urandom_range(0, 99);
        ofs = $urandom_range(0, 3) == 0 ? 2000 : 600;
        k = (gen_filled > 0) ? $urandom_range(0, gen_filled - 1) : 0;
        if (pick < 45 && gen_filled > 0) begin
            add_word(1'b0, $urandom_range(0, 9) == 0, 1'b1,
                     clamp_coord(gen_x[k] + $urandom_range(0, 2 * ofs) - ofs),
                     clamp_coord(gen_y[k] + $urandom_range(0, 2 * ofs) - ofs),
                     clamp_coord(gen_z[k] + $urandom_range(0, 2 * ofs) - ofs),
                     1'($urandom_range(0, 1)), $urandom);
        end else if (pick < 70 && gen_filled > 0) begin
            add_word(1'b1, 1'($urandom_range(0, 1)), 1'b1,
                     clamp_coord(gen_x[k] + $urandom_range(0, 400) - 200),
                     clamp_coord(gen_y[k] + $urandom_range(0, 400) - 200),
                     clamp_coord(gen_z[k] + $urandom_range(0, 400) - 200),
                     1'b1, k);
        end else if (pick < 80 && gen_filled < 80) begin
            add_word(1'b1, 1'b0, 1'b1, $urandom_range(0, 40000) - 20000,
                     $urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                     1'b0, $urandom);
        end else begin
            add_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 3) != 0, $urandom, $urandom, $urandom,
                     gen_filled >= 80, $urandom);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset radius.
        add_word(1'b0, 1'b0, 1'b1, 0, 0, 0, 1'b0, 0);                 // empty table
        add_word(1'b0, 1'b1, 1'b0, 0, 0, 0, 1'b0, 0);                 // invalid match
        add_word(1'b1, 1'b0, 1'b0, 5, 5, 5, 1'b1, 0);                 // invalid merge
        add_word(1'b1, 1'b0, 1'b1, 8388607, 8388607, 8388607, 1'b1, 5); // id not filled
        add_word(1'b1, 1'b0, 1'b1, -8388608, -8388608, -8388608, 1'b0, 1023);
        add_word(1'b1, 1'b0, 1'b1, 0, 0, 0, 1'b0, 0);
        add_word(1'b1, 1'b0, 1'b1, 1000, 0, 0, 1'b0, 0);
        add_word(1'b0, 1'b0, 1'b1, 0, 0, 0, 1'b0, 0);
        add_word(1'b0, 1'b0, 1'b1, 0, 0, 0, 1'b0, 0);
        add_word(1'b0, 1'b0, 1'b1, 0, 0, 0, 1'b0, 0);                 // all in-radius entries used
        add_word(1'b0, 1'b1, 1'b1, 0, 0, 0, 1'b1, 1023);
        add_word(1'b1, 1'b0, 1'b1, 3, -3, 1, 1'b1, 2);
        add_word(1'b1, 1'b1, 1'b1, -7, 7, -1, 1'b1, 2);               // frame start ignored
        add_word(1'b1, 1'b0, 1'b1, 8388607, 8388607, 8388607, 1'b1, 0);
        add_word(1'b1, 1'b0, 1'b1, -8388608, -8388608, -8388608, 1'b1, 1);
        add_word(1'b0, 1'b1, 1'b0, 0, 0, 0, 1'b0, 0);                 // invalid clears marks
        add_word(1'b1, 1'b0, 1'b1, 5000, 5000, 10, 1'b0, 0);
        add_word(1'b1, 1'b0, 1'b1, 5000, 5000, -10, 1'b0, 0);
        add_word(1'b0, 1'b1, 1'b1, 5000, 5000, 0, 1'b0, 0);           // tie, lowest index
        add_word(1'b0, 1'b0, 1'b1, 8388607, 8388607, 8388607, 1'b0, 0);
        add_word(1'b0, 1'b0, 1'b1, -8388608, -8388608, -8388608, 1'b0, 0);

        write_radius('0);
        add_word(1'b0, 1'b1, 1'b1, 0, 0, 0, 1'b0, 0);                 // zero radius matches nothing
        write_radius(RADIUS_ALL_ONES);
        add_word(1'b0, 1'b1, 1'b1, 0, 0, 0, 1'b0, 0);
        add_word(1'b0, 1'b0, 1'b1, 8388607, -8388608, 8388607, 1'b0, 0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_radius(lmm_pkg::RADIUS_RESET);
                1: write_radius(lmm_pkg::RADIUS_W'({$urandom, $urandom}));
                2: write_radius(51'd4096);
                default: begin
                    write_radius(51'd1125899906842624);
                    // The last phase runs without idling on either side.
                    calm = 1'b1;
                end
            endcase
            repeat (140) add_random_word();
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
